>>> hw/rtl/mtm_pkg.sv
// Shared constants, types and register codes of the mask template matcher.
`timescale 1ns / 1ps
`default_nettype none
package mtm_pkg;

    // Sizing
    localparam int MAX_CHANNELS  = 256;
    localparam int MAX_TEMPLATES = 64;
    localparam int MAX_BORDERS   = 16;
    localparam int CHUNK_BITS    = 64;

    localparam int NUM_CHUNKS  = (MAX_CHANNELS + CHUNK_BITS - 1) / CHUNK_BITS;
    localparam int TABLE_DEPTH = MAX_TEMPLATES * MAX_BORDERS;
    localparam int TBL_AW      = $clog2(TABLE_DEPTH);
    localparam int POS_W       = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
    localparam int BIT_W       = (CHUNK_BITS > 1) ? $clog2(CHUNK_BITS) : 1;
    localparam int PFX_DEPTH   = MAX_CHANNELS + 1;
    localparam int CH_W        = $clog2(PFX_DEPTH);
    localparam int TI_W        = $clog2(MAX_TEMPLATES + 1);
    localparam int TIX_W       = (MAX_TEMPLATES > 1) ? $clog2(MAX_TEMPLATES) : 1;
    localparam int BJ_W        = $clog2(MAX_BORDERS);
    // widest count: every interval spans a full border range
    localparam int CNT_W       = $clog2((MAX_BORDERS - 1) * 512 + 1);

    // Fixed field widths
    localparam int TI_FW   = 6;
    localparam int BI_FW   = 4;
    localparam int BV_W    = 9;
    localparam int MASK_W  = 64;
    localparam int CHAN_W  = 9;
    localparam int CIDX_W  = 3;
    localparam int CDATA_W = 9;

    // Register indexes
    localparam logic [CIDX_W-1:0] REG_DIFF_LIMIT    = 3'd0;
    localparam logic [CIDX_W-1:0] REG_FIRST_CHANNEL = 3'd1;
    localparam logic [CIDX_W-1:0] REG_TEMPLATE_CNT  = 3'd2;
    localparam logic [CIDX_W-1:0] REG_BORDERS       = 3'd3;
    localparam logic [CIDX_W-1:0] REG_CHANNEL_CNT   = 3'd4;

    localparam logic [CHAN_W-1:0] NO_MATCH = 9'h1FF;

    typedef enum logic [1:0] {
        K_LOAD,
        K_CHUNK,
        K_LAST
    } t_kind;

    typedef struct packed {
        t_kind                 kind;
        logic [TI_FW-1:0]      ti;
        logic [BI_FW-1:0]      bi;
        logic [BV_W-1:0]       bv;
        logic [CHUNK_BITS-1:0] bits;
    } t_cmd;

    typedef struct packed {
        logic [8:0] diff_limit;
        logic [7:0] first_channel;
        logic [6:0] template_count;
        logic [4:0] borders;
        logic [8:0] channel_count;
    } t_cfg;

    typedef struct packed {
        logic busy;
    } t_bstat;

endpackage
`default_nettype wire

>>> hw/rtl/mtm_front.sv
// Front end: accepts words, classifies them and holds them in a short queue.
`timescale 1ns / 1ps
`default_nettype none
module mtm_front
    import mtm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic              i_op,
    input  wire logic [TI_FW-1:0]  i_template_index,
    input  wire logic [BI_FW-1:0]  i_border_index,
    input  wire logic [BV_W-1:0]   i_border_value,
    input  wire logic [MASK_W-1:0] i_mask_bits,
    input  wire logic              i_last_chunk,
    output t_cmd                   o_cmd,
    output logic                   o_cmd_valid,
    input  wire logic              i_pop
);

    localparam int QDEPTH = 2;

    t_cmd       r_q [QDEPTH];
    logic       r_wr, r_rd;
    logic [1:0] r_cnt;
    logic       in_range, push;
    t_cmd       cmd;

    // classify: out-of-range loads are dropped here
    always_comb begin
        in_range  = (int'(i_template_index) < MAX_TEMPLATES) &&
                    (int'(i_border_index) < MAX_BORDERS);
        cmd.ti    = i_template_index;
        cmd.bi    = i_border_index;
        cmd.bv    = i_border_value;
        cmd.bits  = i_mask_bits[CHUNK_BITS-1:0];
        if (!i_op) begin
            cmd.kind = K_LOAD;
        end else if (i_last_chunk) begin
            cmd.kind = K_LAST;
        end else begin
            cmd.kind = K_CHUNK;
        end
    end

    assign o_ready     = (r_cnt != 2'(QDEPTH));
    assign push        = i_valid && o_ready && (i_op || in_range);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rd];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= cmd;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop);
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/mtm_back.sv
// Back end: border table, sample store, prefix counts and the template search.
`timescale 1ns / 1ps
`default_nettype none
module mtm_back
    import mtm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cfg              i_cfg,
    input  wire t_cmd              i_cmd,
    input  wire logic              i_cmd_valid,
    output logic                   o_pop,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [CHAN_W-1:0]      o_channel,
    output t_bstat                 o_stat
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_BUILD,
        S_EVAL,
        S_DRAIN,
        S_DONE
    } t_state;

    t_state r_state;

    // memories and store
    logic [BV_W-1:0]       r_tbl [TABLE_DEPTH];
    logic [CH_W-1:0]       r_pfx [PFX_DEPTH];
    logic [CHUNK_BITS-1:0] r_store [NUM_CHUNKS];
    logic [BV_W-1:0]       r_tbl_q;
    logic [CH_W-1:0]       r_pa_q, r_pb_q;

    logic [POS_W-1:0] r_pos;
    logic [CH_W-1:0]  r_c, r_run;
    logic [TI_W-1:0]  r_ti;
    logic [BJ_W-1:0]  r_bj;

    // pipeline stage 1: border data
    logic             r_s1_v, r_s1_end, r_s1_fin;
    logic [BJ_W-1:0]  r_s1_bj;
    logic [TIX_W-1:0] r_s1_ti;
    logic [BV_W-1:0]  r_prev;
    // stage 2: prefix data
    logic             r_s2_v, r_s2_int, r_s2_want1, r_s2_start, r_s2_end, r_s2_fin;
    logic [BV_W-1:0]  r_s2_len;
    logic [TIX_W-1:0] r_s2_ti;
    logic [CNT_W-1:0] r_acc;
    // stage 3: compare
    logic             r_s3_v, r_s3_fin;
    logic [TIX_W-1:0] r_s3_ti;
    logic [CNT_W-1:0] r_best;
    logic [TIX_W-1:0] r_win;
    logic             r_found;

    logic                 r_out_valid;
    logic [CHAN_W-1:0]    r_out_channel;

    // derived settings
    logic [TI_W-1:0]  nt;
    logic [BJ_W-1:0]  jlast;
    logic [CH_W-1:0]  nch;
    logic [4:0]       nb;
    logic             issue, tbl_we, bit_in, s1_int;
    logic [TBL_AW-1:0] tbl_ra, tbl_wa;
    logic [CH_W-1:0]  pa, pb, ones;
    logic [BV_W-1:0]  s1_len;
    logic [BV_W-1:0]  mism;
    logic [CNT_W-1:0] acc_next;
    logic [8:0]       chan_sum;

    always_comb begin
        nt    = (int'(i_cfg.template_count) > MAX_TEMPLATES) ? TI_W'(MAX_TEMPLATES)
                                                              : TI_W'(i_cfg.template_count);
        nb    = (int'(i_cfg.borders) > MAX_BORDERS) ? 5'(MAX_BORDERS) : i_cfg.borders;
        jlast = (nb == 5'd0) ? '0 : BJ_W'(nb - 5'd1);
        nch   = (int'(i_cfg.channel_count) > MAX_CHANNELS) ? CH_W'(MAX_CHANNELS)
                                                            : CH_W'(i_cfg.channel_count);
    end

    assign o_pop  = (r_state == S_IDLE) && i_cmd_valid;
    assign tbl_we = o_pop && (i_cmd.kind == K_LOAD);
    assign tbl_wa = TBL_AW'(int'(i_cmd.ti) * MAX_BORDERS + int'(i_cmd.bi));
    assign issue  = (r_state == S_EVAL);
    assign tbl_ra = TBL_AW'(int'(r_ti) * MAX_BORDERS + int'(r_bj));

    // mask bit of the channel being summed
    assign bit_in = (r_c < nch) ?
                    r_store[POS_W'(r_c / CHUNK_BITS)][BIT_W'(r_c % CHUNK_BITS)] : 1'b0;

    // stage 1: interval end points, clamped to the prefix range
    always_comb begin
        s1_int = r_s1_v && (r_s1_bj != '0) && (r_tbl_q > r_prev);
        s1_len = r_tbl_q - r_prev;
        pa     = (int'(r_prev) > MAX_CHANNELS) ? CH_W'(MAX_CHANNELS) : CH_W'(r_prev);
        pb     = (int'(r_tbl_q) > MAX_CHANNELS) ? CH_W'(MAX_CHANNELS) : CH_W'(r_tbl_q);
    end

    // stage 2: mismatches of one interval, added to the running count
    always_comb begin
        ones = r_pb_q - r_pa_q;
        if (!r_s2_int) begin
            mism = '0;
        end else if (r_s2_want1) begin
            mism = r_s2_len - BV_W'(ones);
        end else begin
            mism = BV_W'(ones);
        end
        acc_next = (r_s2_start ? '0 : r_acc) + CNT_W'(mism);
    end

    assign chan_sum = 9'(i_cfg.first_channel) + 9'(r_win);

    // border table
    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_tbl[tbl_wa] <= i_cmd.bv;
        end
        r_tbl_q <= r_tbl[tbl_ra];
    end

    // prefix count memory
    always_ff @(posedge i_clk) begin
        if (r_state == S_BUILD) begin
            r_pfx[r_c] <= r_run;
        end
        r_pa_q <= r_pfx[pa];
        r_pb_q <= r_pfx[pb];
    end

    // sample store, cleared after each sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_CHUNKS; k++) begin
                r_store[k] <= '0;
            end
        end else if (o_pop && (i_cmd.kind != K_LOAD)) begin
            r_store[r_pos] <= i_cmd.bits;
        end else if ((r_state == S_BUILD) && (int'(r_c) == MAX_CHANNELS)) begin
            for (int k = 0; k < NUM_CHUNKS; k++) begin
                r_store[k] <= '0;
            end
        end
    end

    // sequencer, search pipeline and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_c         <= '0;
            r_run       <= '0;
            r_ti        <= '0;
            r_bj        <= '0;
            r_s1_v      <= 1'b0;
            r_s2_v      <= 1'b0;
            r_s3_v      <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // taken result; a waiting search reloads it in S_DONE instead
            if (r_out_valid && i_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            // pipeline, runs in every state
            r_s1_v   <= issue;
            r_s1_bj  <= r_bj;
            r_s1_end <= (r_bj == jlast);
            r_s1_fin <= (r_ti == nt - TI_W'(1));
            r_s1_ti  <= r_ti[TIX_W-1:0];
            if (r_s1_v) begin
                r_prev <= r_tbl_q;
            end
            r_s2_v     <= r_s1_v;
            r_s2_int   <= s1_int;
            r_s2_want1 <= ~r_s1_bj[0];
            r_s2_len   <= s1_len;
            r_s2_start <= (r_s1_bj == '0);
            r_s2_end   <= r_s1_end;
            r_s2_fin   <= r_s1_fin;
            r_s2_ti    <= r_s1_ti;
            if (r_s2_v) begin
                r_acc <= acc_next;
            end
            r_s3_v   <= r_s2_v && r_s2_end;
            r_s3_fin <= r_s2_fin;
            r_s3_ti  <= r_s2_ti;
            if (r_s3_v && (r_acc < r_best)) begin
                r_best  <= r_acc;
                r_win   <= r_s3_ti;
                r_found <= 1'b1;
            end

            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        case (i_cmd.kind)
                            K_CHUNK: begin
                                r_pos <= (r_pos == POS_W'(NUM_CHUNKS - 1)) ? '0
                                                                : r_pos + POS_W'(1);
                            end
                            K_LAST: begin
                                r_pos   <= '0;
                                r_c     <= '0;
                                r_run   <= '0;
                                r_state <= S_BUILD;
                            end
                            default: ;
                        endcase
                    end
                end
                S_BUILD: begin
                    r_run <= r_run + CH_W'(bit_in);
                    r_c   <= r_c + CH_W'(1);
                    if (int'(r_c) == MAX_CHANNELS) begin
                        r_ti    <= '0;
                        r_bj    <= '0;
                        r_best  <= CNT_W'(i_cfg.diff_limit);
                        r_found <= 1'b0;
                        r_state <= (nt == '0) ? S_DONE : S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (r_bj == jlast) begin
                        r_bj <= '0;
                        if (r_ti == nt - TI_W'(1)) begin
                            r_state <= S_DRAIN;
                        end else begin
                            r_ti <= r_ti + TI_W'(1);
                        end
                    end else begin
                        r_bj <= r_bj + BJ_W'(1);
                    end
                end
                S_DRAIN: begin
                    if (r_s3_v && r_s3_fin) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid <= 1'b1;
                        if (!r_found) begin
                            r_out_channel <= NO_MATCH;
                        end else if (chan_sum > 9'd255) begin
                            r_out_channel <= 9'd255;
                        end else begin
                            r_out_channel <= chan_sum;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid     = r_out_valid;
    assign o_channel   = r_out_channel;
    assign o_stat.busy = (r_state != S_IDLE);

endmodule
`default_nettype wire

>>> hw/rtl/mask_template_matcher.sv
// Top level of the mask template matcher: configuration registers, front and back ends.
//
// Input channel (i_valid/o_ready): one word per accept. i_op = 0 loads one border
// into the template table; i_op = 1 delivers a 64-bit mask chunk, i_last_chunk
// closing the sample. Words pass through a two-entry queue to the back end.
// Loads and non-final chunks are taken while the back end stays idle.
// A final chunk starts a search: the back end builds per-channel prefix counts,
// then reads one border per cycle, max(nb, 1) for each of nt templates, where nt
// and nb are the saturated template and border counts, and last drains the
// search pipeline into the output register; no new word is taken meanwhile.
// Output channel (o_valid/i_ready): one word per sample, the matched channel
// or -1. A stalled receiver holds the result in the output register; the
// queue keeps accepting until it fills, then o_ready drops.
// Reset clears control state, the sample store and the registers to their
// defaults; the border table holds nothing valid until loaded.
// Configuration (i_cfg_we): user writes only while idle; the block does not check.
`timescale 1ns / 1ps
`default_nettype none
module mask_template_matcher
    import mtm_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [CIDX_W-1:0]  i_cfg_index,
    input  wire logic [CDATA_W-1:0] i_cfg_data,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic               i_op,
    input  wire logic [TI_FW-1:0]   i_template_index,
    input  wire logic [BI_FW-1:0]   i_border_index,
    input  wire logic [BV_W-1:0]    i_border_value,
    input  wire logic [MASK_W-1:0]  i_mask_bits,
    input  wire logic               i_last_chunk,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [CHAN_W-1:0] o_channel
);

    t_cfg   r_cfg;
    t_cmd   cmd;
    logic   cmd_valid;
    logic   pop;
    t_bstat bstat;
    logic [CHAN_W-1:0] channel;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.diff_limit     <= 9'd16;
            r_cfg.first_channel  <= 8'd0;
            r_cfg.template_count <= 7'd64;
            r_cfg.borders        <= 5'd16;
            r_cfg.channel_count  <= 9'd256;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_DIFF_LIMIT:    r_cfg.diff_limit     <= i_cfg_data[8:0];
                REG_FIRST_CHANNEL: r_cfg.first_channel  <= i_cfg_data[7:0];
                REG_TEMPLATE_CNT:  r_cfg.template_count <= i_cfg_data[6:0];
                REG_BORDERS:       r_cfg.borders        <= i_cfg_data[4:0];
                REG_CHANNEL_CNT:   r_cfg.channel_count  <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    mtm_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_op             (i_op),
        .i_template_index (i_template_index),
        .i_border_index   (i_border_index),
        .i_border_value   (i_border_value),
        .i_mask_bits      (i_mask_bits),
        .i_last_chunk     (i_last_chunk),
        .o_cmd            (cmd),
        .o_cmd_valid      (cmd_valid),
        .i_pop            (pop)
    );

    mtm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_channel   (channel),
        .o_stat      (bstat)
    );

    assign o_channel = signed'(channel);

    // back end only takes a word the queue holds
    a_pop_has_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> cmd_valid)
        else $error("back end popped an empty queue");

    // no result straight out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // a result is either no match or a channel in range
    a_channel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (channel == NO_MATCH || channel[CHAN_W-1] == 1'b0))
        else $error("result channel out of range");

    // a new result only appears while the back end is finishing a search
    a_result_from_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(bstat.busy))
        else $error("result without a search");

endmodule
`default_nettype wire

>>> verif/mask_template_matcher_tb.sv
// Self-checking testbench of the mask template matcher: directed table, then random samples.
`timescale 1ns / 1ps
module mask_template_matcher_tb;
    import mtm_pkg::*;

    typedef struct {
        bit               op;
        bit [TI_FW-1:0]   ti;
        bit [BI_FW-1:0]   bi;
        bit [BV_W-1:0]    bv;
        bit [MASK_W-1:0]  bits;
        bit               last;
        bit               typed;
        bit [CHAN_W-1:0]  chan;
    } t_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [CIDX_W-1:0]   i_cfg_index = '0;
    logic [CDATA_W-1:0]  i_cfg_data = '0;
    logic                i_valid = 1'b0;
    logic                o_ready;
    logic                i_op = 1'b0;
    logic [TI_FW-1:0]    i_template_index = '0;
    logic [BI_FW-1:0]    i_border_index = '0;
    logic [BV_W-1:0]     i_border_value = '0;
    logic [MASK_W-1:0]   i_mask_bits = '0;
    logic                i_last_chunk = 1'b0;
    logic                o_valid;
    logic                i_ready = 1'b1;
    logic signed [CHAN_W-1:0] o_channel;

    // Predictor state: registers, border table, sample store
    int unsigned         md_reg, fc_reg, tc_reg, nb_reg, ch_reg;
    bit [BV_W-1:0]       borders[TABLE_DEPTH];
    bit                  loaded[TABLE_DEPTH];
    bit [MASK_W-1:0]     chunks[NUM_CHUNKS];
    int unsigned         chunk_pos;

    bit [CHAN_W-1:0]     channel_q[$];
    t_row                rows[$];
    int                  errors = 0;
    bit                  tx_calm = 1'b0;
    bit                  rx_calm = 1'b0;
    int                  rx_hold = 0;

    mask_template_matcher i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_op             (i_op),
        .i_template_index (i_template_index),
        .i_border_index   (i_border_index),
        .i_border_value   (i_border_value),
        .i_mask_bits      (i_mask_bits),
        .i_last_chunk     (i_last_chunk),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_channel        (o_channel)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Hard stop
    initial begin
        #4000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic int unsigned sat(int unsigned v, int unsigned lim);
        return (v > lim) ? lim : v;
    endfunction

    // Best template over the stored sample
    function automatic bit [CHAN_W-1:0] match_channel();
        int unsigned nt, nb, nch, best, win, cnt, lo, hi;
        bit found, mbit, want;
        nt = sat(tc_reg, MAX_TEMPLATES);
        nb = sat(nb_reg, MAX_BORDERS);
        nch = sat(ch_reg, MAX_CHANNELS);
        best = md_reg;
        found = 1'b0;
        win = 0;
        for (int unsigned i = 0; i < nt; i++) begin
            cnt = 0;
            for (int unsigned j = 1; j < nb; j++) begin
                want = (j % 2 == 0);
                lo = 32'(borders[i*MAX_BORDERS + j - 1]);
                hi = 32'(borders[i*MAX_BORDERS + j]);
                for (int unsigned k = lo; k < hi; k++) begin
                    mbit = (k < nch) ? chunks[k / CHUNK_BITS][k % CHUNK_BITS] : 1'b0;
                    if (mbit != want) cnt++;
                end
            end
            if (cnt < best) begin
                best = cnt;
                win = i;
                found = 1'b1;
            end
        end
        if (!found) return NO_MATCH;
        return CHAN_W'(sat(win + fc_reg, 255));
    endfunction

    // Predictor step for one accepted word; a typed value overrides the prediction
    task automatic absorb_word(t_row r);
        bit [CHAN_W-1:0] chan;
        if (!r.op) begin
            borders[r.ti*MAX_BORDERS + r.bi] = r.bv;
            loaded[r.ti*MAX_BORDERS + r.bi] = 1'b1;
        end else begin
            chunks[chunk_pos % NUM_CHUNKS] = r.bits;
            if (!r.last) begin
                chunk_pos = (chunk_pos + 1) % NUM_CHUNKS;
            end else begin
                chan = match_channel();
                channel_q.push_back(r.typed ? r.chan : chan);
                foreach (chunks[n]) chunks[n] = '0;
                chunk_pos = 0;
            end
        end
    endtask

    task automatic send_word(t_row r);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_op <= r.op;
        i_template_index <= r.ti;
        i_border_index <= r.bi;
        i_border_value <= r.bv;
        i_mask_bits <= r.bits;
        i_last_chunk <= r.last;
        do @(posedge i_clk); while (!o_ready);
        absorb_word(r);
    endtask

    task automatic send_load(int unsigned ti, int unsigned bi, int unsigned bv);
        t_row r;
        r = '{op: 1'b0, ti: TI_FW'(ti), bi: BI_FW'(bi), bv: BV_W'(bv),
              bits: MASK_W'($urandom), last: 1'b0, typed: 1'b0, chan: '0};
        send_word(r);
    endtask

    // One sample from a 256-bit channel vector, split into chunks
    task automatic send_sample(bit [MAX_CHANNELS-1:0] vec, int nchunk);
        t_row r;
        for (int n = 0; n < nchunk; n++) begin
            r = '{op: 1'b1, ti: TI_FW'($urandom), bi: BI_FW'($urandom),
                  bv: BV_W'($urandom),
                  bits: vec[(n % NUM_CHUNKS)*CHUNK_BITS +: CHUNK_BITS],
                  last: (n == nchunk - 1), typed: 1'b0, chan: '0};
            send_word(r);
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (channel_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CIDX_W-1:0] idx, int unsigned val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= CDATA_W'(val);
        @(posedge i_clk);
        case (idx)
            REG_DIFF_LIMIT:    md_reg = val & 32'h1FF;
            REG_FIRST_CHANNEL: fc_reg = val & 32'hFF;
            REG_TEMPLATE_CNT:  tc_reg = val & 32'h7F;
            REG_BORDERS:       nb_reg = val & 32'h1F;
            REG_CHANNEL_CNT:   ch_reg = val & 32'h1FF;
            default: ;
        endcase
    endtask

    task automatic configure(int unsigned md, int unsigned fc, int unsigned tc,
                             int unsigned nb, int unsigned ch);
        write_reg(REG_DIFF_LIMIT, md);
        write_reg(REG_FIRST_CHANNEL, fc);
        write_reg(REG_TEMPLATE_CNT, tc);
        write_reg(REG_BORDERS, nb);
        write_reg(REG_CHANNEL_CNT, ch);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic add_row(bit op, int ti, int bi, int bv, bit [MASK_W-1:0] bits,
                           bit last, bit typed, bit [CHAN_W-1:0] chan);
        rows.push_back('{op: op, ti: TI_FW'(ti), bi: BI_FW'(bi), bv: BV_W'(bv),
                         bits: bits, last: last, typed: typed, chan: chan});
    endtask

    // Random phase: fill rows in use, then mostly well-formed samples
    task automatic run_phase(int words);
        int unsigned nt, nb, nch, t, val, sent, pick;
        bit [MAX_CHANNELS-1:0] vec;
        nt = sat(tc_reg, MAX_TEMPLATES);
        nb = sat(nb_reg, MAX_BORDERS);
        nch = sat(ch_reg, MAX_CHANNELS);
        for (int unsigned i = 0; i < nt; i++)
            for (int unsigned b = 0; b < nb; b++)
                if (!loaded[i*MAX_BORDERS + b])
                    send_load(i, b, (b * nch) / nb + $urandom_range(0, 7));
        sent = 0;
        while (sent < words) begin
            pick = $urandom_range(0, 9);
            if (pick < 6 && nt > 0) begin
                // sample close to one template, a few channels flipped
                t = $urandom_range(0, nt - 1);
                vec = '0;
                for (int unsigned j = 1; j < nb; j++)
                    for (int unsigned k = borders[t*MAX_BORDERS + j - 1];
                         k < borders[t*MAX_BORDERS + j] && k < MAX_CHANNELS; k++)
                        vec[k] = (j % 2 == 0);
                repeat ($urandom_range(0, 20)) vec[$urandom_range(0, MAX_CHANNELS - 1)] ^= 1'b1;
                send_sample(vec, (nch + CHUNK_BITS - 1) / CHUNK_BITS);
                sent += (nch + CHUNK_BITS - 1) / CHUNK_BITS;
            end else if (pick < 8) begin
                // noise sample, random chunk count from 1 to 6, including wrap-around
                for (int n = 0; n < NUM_CHUNKS; n++)
                    vec[n*CHUNK_BITS +: CHUNK_BITS] = {$urandom, $urandom};
                val = $urandom_range(1, 6);
                send_sample(vec, val);
                sent += val;
            end else if (pick < 9 && nt > 0) begin
                val = $urandom_range(0, nb - 1);
                send_load($urandom_range(0, nt - 1), val,
                          (val * nch) / nb + $urandom_range(0, 15));
                sent++;
            end else begin
                send_load($urandom_range(0, 63), $urandom_range(0, 15),
                          $urandom_range(0, 511));
                sent++;
            end
        end
        wait_drained();
    endtask

    // Result checker and receiver stalls
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (channel_q.size() == 0) begin
                    $display("%0t: unexpected word, channel %0d", $time, o_channel);
                    errors++;
                end else if (o_channel !== channel_q[0]) begin
                    $display("%0t: channel expected %0d got %0d", $time,
                             $signed(channel_q[0]), o_channel);
                    errors++;
                    void'(channel_q.pop_front());
                end else begin
                    void'(channel_q.pop_front());
                end
                rx_hold = rx_calm ? 0 : $urandom_range(0, 3);
                if (rx_hold != 0) i_ready <= 1'b0;
            end else if (!i_ready) begin
                if (rx_hold <= 1) i_ready <= 1'b1;
                rx_hold = rx_hold - 1;
            end
        end
    end

    initial begin
        md_reg = 16; fc_reg = 0; tc_reg = 64; nb_reg = 16; ch_reg = 256;
        chunk_pos = 0;
        foreach (chunks[n]) chunks[n] = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: one template, channels 0..63 expected clear
        configure(16, 0, 1, 2, 256);
        add_row(0, 0, 0, 0, '0, 0, 0, '0);
        add_row(0, 0, 1, 64, '0, 0, 0, '0);
        add_row(1, 0, 0, 0, '0, 1, 1, 9'd0);
        add_row(1, 0, 0, 0, '1, 1, 1, NO_MATCH);
        add_row(0, 63, 15, 511, '0, 0, 0, '0);
        add_row(0, 0, 1, 0, '0, 0, 0, '0);
        add_row(1, 0, 0, 0, '1, 0, 0, '0);
        add_row(1, 0, 0, 0, '1, 1, 1, 9'd0);
        add_row(0, 0, 1, 256, '0, 0, 0, '0);
        repeat (4) add_row(1, 0, 0, 0, '0, 0, 0, '0);
        add_row(1, 0, 0, 0, '1, 1, 0, '0);
        add_row(0, 0, 0, 5, '0, 0, 0, '0);
        add_row(1, 0, 0, 0, 64'hA5A5_0F0F_FFFF_0000, 0, 0, '0);
        add_row(1, 0, 0, 0, 64'h8000_0000_0000_0001, 1, 0, '0);
        add_row(0, 0, 1, 300, '0, 0, 0, '0);
        add_row(1, 0, 0, 0, '0, 1, 0, '0);
        foreach (rows[r]) send_word(rows[r]);
        wait_drained();

        // Random phases over several settings, extremes included
        configure(16, 0, 4, 4, 256);      run_phase(30);
        tx_calm = 1'b1;
        configure(0, 10, 8, 8, 200);      run_phase(30);
        tx_calm = 1'b0; rx_calm = 1'b1;
        configure(257, 255, 12, 16, 256); run_phase(30);
        rx_calm = 1'b0;
        configure(5, 250, 64, 2, 256);    run_phase(30);
        configure(16, 0, 1, 2, 1);        run_phase(20);
        tx_calm = 1'b1; rx_calm = 1'b1;
        configure(100, 128, 127, 2, 511); run_phase(30);
        tx_calm = 1'b0; rx_calm = 1'b0;
        configure(60, 20, 12, 31, 130);   run_phase(30);
        configure(3, 7, 0, 5, 64);        run_phase(20);
        configure(40, 33, 12, 1, 130);    run_phase(20);
        configure(16, 0, 12, 16, 256);    run_phase(30);
        configure(200, 1, 20, 6, 90);     run_phase(30);

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
